// ===== hw/rtl/depth_test_pixel_write_defines.svh =====
// assertion macros for the depth test and pixel write block
`ifndef DEPTH_TEST_PIXEL_WRITE_DEFINES_SVH
`define DEPTH_TEST_PIXEL_WRITE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DTPW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define DTPW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dtpw_pkg.sv =====
// shared constants and helpers for the depth test and pixel write block
package dtpw_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FB_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_FB_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_COLOR_FORMAT = 2'd2;
    localparam logic [1:0] CFG_DEPTH_MODE   = 2'd3;

    // color formats
    localparam logic [1:0] COLOR_LUMA   = 2'd0;
    localparam logic [1:0] COLOR_RGB565 = 2'd1;
    localparam logic [1:0] COLOR_ARGB   = 2'd2;

    // depth modes
    localparam logic [1:0] DEPTH_OFF = 2'd0;
    localparam logic [1:0] DEPTH_16  = 2'd1;
    localparam logic [1:0] DEPTH_24  = 2'd2;
    localparam logic [1:0] DEPTH_32  = 2'd3;

    // depth operations
    localparam logic [1:0] DOP_PLAIN    = 2'd0;
    localparam logic [1:0] DOP_TESTED   = 2'd1;
    localparam logic [1:0] DOP_UNTESTED = 2'd2;

    // luma weights and divide by 100 as multiply by 5243 then shift by 19
    localparam int          LUMA_SUM_W = 15;
    localparam logic [14:0] LUMA_WR    = 15'd30;
    localparam logic [14:0] LUMA_WG    = 15'd59;
    localparam logic [14:0] LUMA_WB    = 15'd11;
    localparam logic [12:0] LUMA_RECIP = 13'd5243;
    localparam int          LUMA_SHIFT = 19;

    localparam logic [31:0] DEPTH_FAR = 32'hffff_ffff;

    function automatic logic [LUMA_SUM_W-1:0] luma_sum(input logic [31:0] c);
        logic [14:0] r;
        logic [14:0] g;
        logic [14:0] b;
        r = {7'd0, c[23:16]};
        g = {7'd0, c[15:8]};
        b = {7'd0, c[7:0]};
        return r * LUMA_WR + g * LUMA_WG + b * LUMA_WB;
    endfunction

endpackage

// ===== hw/rtl/dtpw_depth_ram.sv =====
// single-port-write, single-port-read depth memory with registered read data
module dtpw_depth_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // read returns the old word when the same entry is written in that cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/dtpw_color_pack.sv =====
// color packing into luma index, rgb565 or argb
module dtpw_color_pack
    import dtpw_pkg::*;
(
    input  logic [1:0]            i_format,
    input  logic [31:0]           i_color,
    input  logic [LUMA_SUM_W-1:0] i_luma_sum,
    output logic [31:0]           o_word
);

    logic [27:0] luma_prod;
    logic [7:0]  luma;

    assign luma_prod = 28'(i_luma_sum) * 28'(LUMA_RECIP);
    assign luma      = luma_prod[LUMA_SHIFT +: 8];

    always_comb begin
        unique case (i_format)
            COLOR_LUMA:   o_word = {24'd0, luma};
            COLOR_RGB565: o_word = {16'd0, i_color[23:19], i_color[15:10], i_color[7:3]};
            default:      o_word = i_color;
        endcase
    end

endmodule

// ===== hw/rtl/depth_test_pixel_write.sv =====
// top level: fragment depth test against the depth memory and pixel packing
// pipeline: an input beat is registered in stage 1, then in the output register for the result
// throughput: one fragment per cycle unless stalled, set by the single depth RAM read and write port
// reset: synchronous active-low; after reset a clearing pass writes far depth to all
// MAX_WIDTH*MAX_HEIGHT entries, one per cycle, and no input beat is taken until it ends
// configuration writes are taken at any time, also during the clearing pass
module depth_test_pixel_write
    import dtpw_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    // fragment input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [31:0] i_frag_depth,
    input  logic [31:0] i_frag_color,
    input  logic [1:0]  i_depth_op,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_color_written,
    output logic [15:0] o_pixel_index,
    output logic [31:0] o_pixel_value,
    output logic        o_depth_written
);

`include "depth_test_pixel_write_defines.svh"

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [8:0] r_fb_width;
    logic [8:0] r_fb_height;
    logic [1:0] r_color_format;
    logic [1:0] r_depth_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width     <= 9'd256;
            r_fb_height    <= 9'd256;
            r_color_format <= COLOR_ARGB;
            r_depth_mode   <= DEPTH_32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FB_WIDTH:     r_fb_width     <= i_cfg_data;
                CFG_FB_HEIGHT:    r_fb_height    <= i_cfg_data;
                CFG_COLOR_FORMAT: r_color_format <= i_cfg_data[1:0];
                CFG_DEPTH_MODE:   r_depth_mode   <= i_cfg_data[1:0];
                default:          r_fb_width     <= r_fb_width;
            endcase
        end
    end

    // clearing pass after reset
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // stage 1 registers: fragment waiting for its depth word
    logic                  r_s1_valid;
    logic                  r_s1_inrange;
    logic                  r_s1_test;
    logic                  r_s1_force;
    logic [AW-1:0]         r_s1_addr;
    logic [15:0]           r_s1_idx;
    logic [31:0]           r_s1_du;
    logic [31:0]           r_s1_mask;
    logic [31:0]           r_s1_color;
    logic [LUMA_SUM_W-1:0] r_s1_luma_sum;
    logic                  r_s1_fwd_hit;
    logic [31:0]           r_s1_fwd_data;

    // output register
    logic        r_out_valid;
    logic        r_out_cw;
    logic [15:0] r_out_idx;
    logic [31:0] r_out_value;
    logic        r_out_dw;

    // handshakes: stage 1 moves on when the output register is free or drains
    logic s1_adv;
    logic in_acc;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_acc     = i_in_valid && o_in_ready;

    // stage 0: bounds, pixel index, depth scaling
    logic [8:0]  eff_w;
    logic [8:0]  eff_h;
    logic        in_range;
    logic [17:0] idx18;
    logic [31:0] idx32;
    logic [AW-1:0] rd_addr;
    logic        test_en;
    logic [31:0] du;
    logic [31:0] dmask;

    assign eff_w = ({23'd0, r_fb_width} > 32'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : r_fb_width;
    assign eff_h = ({23'd0, r_fb_height} > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : r_fb_height;

    // negative coordinates read as large unsigned values and fall outside
    assign in_range = (i_pos_x < {7'd0, eff_w}) && (i_pos_y < {7'd0, eff_h});

    assign idx18   = {9'd0, i_pos_y[8:0]} * {9'd0, eff_w} + {9'd0, i_pos_x[8:0]};
    assign idx32   = 32'(idx18);
    assign rd_addr = idx32[AW-1:0];

    assign test_en = ((i_depth_op == DOP_TESTED) || (i_depth_op == DOP_UNTESTED))
                     && (r_depth_mode != DEPTH_OFF);

    always_comb begin
        unique case (r_depth_mode)
            DEPTH_16: begin
                du    = {16'd0, i_frag_depth[31:16]};
                dmask = 32'h0000_ffff;
            end
            DEPTH_24: begin
                du    = {8'd0, i_frag_depth[31:8]};
                dmask = 32'h00ff_ffff;
            end
            default: begin
                du    = i_frag_depth;
                dmask = DEPTH_FAR;
            end
        endcase
    end

    // stage 1: compare against stored depth, with forwarding of a same-cycle write
    logic [31:0] ram_rdata;
    logic [31:0] cur_depth;
    logic        s1_pass;
    logic        s1_dw;
    logic        s1_cw;

    assign cur_depth = (r_s1_fwd_hit ? r_s1_fwd_data : ram_rdata) & r_s1_mask;
    assign s1_pass   = r_s1_du < cur_depth;
    assign s1_dw     = r_s1_inrange && r_s1_test && s1_pass;
    assign s1_cw     = r_s1_inrange && (!r_s1_test || r_s1_force || s1_pass);

    // memory write port: clearing pass, else depth update as stage 1 moves on
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;

    assign ram_we    = r_clr_busy || (s1_adv && s1_dw);
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clr_busy ? DEPTH_FAR : r_s1_du;

    dtpw_depth_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (32)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage 1 payload; forward the word written in the cycle this read happens
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_inrange  <= in_range;
            r_s1_test     <= test_en;
            r_s1_force    <= (i_depth_op == DOP_UNTESTED);
            r_s1_addr     <= rd_addr;
            r_s1_idx      <= idx18[15:0];
            r_s1_du       <= du;
            r_s1_mask     <= dmask;
            r_s1_color    <= i_frag_color;
            r_s1_luma_sum <= luma_sum(i_frag_color);
            r_s1_fwd_hit  <= ram_we && (ram_waddr == rd_addr);
            r_s1_fwd_data <= ram_wdata;
        end
    end

    // color packing between stage 1 and the output register
    logic [31:0] packed_word;

    dtpw_color_pack u_color_pack (
        .i_format   (r_color_format),
        .i_color    (r_s1_color),
        .i_luma_sum (r_s1_luma_sum),
        .o_word     (packed_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // fragments that write no color (out of range, or failing a tested depth op) report all-zero fields
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_cw    <= s1_cw;
            r_out_idx   <= s1_cw ? r_s1_idx : 16'd0;
            r_out_value <= s1_cw ? packed_word : 32'd0;
            r_out_dw    <= s1_dw;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_color_written = r_out_cw;
    assign o_pixel_index   = r_out_idx;
    assign o_pixel_value   = r_out_value;
    assign o_depth_written = r_out_dw;

    // checks
    `DTPW_ASSERT_NEXT(a_clear_once, !r_clr_busy, !r_clr_busy, "clearing pass restarted")
    `DTPW_ASSERT_NOW(a_dw_implies_cw, r_out_valid && r_out_dw, r_out_cw,
        "depth written without color written")
    `DTPW_ASSERT_NOW(a_no_cw_zero, r_out_valid && !r_out_cw,
        (r_out_idx == 16'd0) && (r_out_value == 32'd0), "dropped beat has nonzero fields")
    `DTPW_ASSERT_NOW(a_update_on_adv, ram_we && !r_clr_busy, s1_adv && r_s1_inrange,
        "depth update outside a stage advance")

endmodule
